/* hw/rtl/hrlt_pkg.sv */
// Package with shared types, status codes and sizes for the record lock table.
package hrlt_pkg;

  localparam int unsigned BucketsDefault = 256;
  localparam int unsigned EntriesDefault = 1024;
  localparam int unsigned HandlesDefault = 256;

  localparam int unsigned TableW  = 10;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 8;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    StGranted   = 3'd0,
    StQueued    = 3'd1,
    StReleased  = 3'd2,
    StWaiter    = 3'd3,
    StRecFull   = 3'd4,
    StPoolFull  = 3'd5,
    StBadHandle = 3'd6
  } status_e;

  typedef enum logic {
    OpAcquire = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    SIdle,
    SBktRd,
    SHash,
    SWalkRd,
    SWalkCmp,
    SHandleScan,
    SDecide,
    SQueueRd,
    SRelRd,
    SRelChk,
    SRelWait,
    SRelNext,
    SOut1,
    SOut2
  } state_e;

  // Handshake between the sequencer and the free-handle scanner.
  typedef struct packed {
    logic start;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_rsp_t;

endpackage

/* hw/rtl/hrlt_handle_scan.sv */
// Free-handle scanner that finds the lowest free lock handle, one handle per cycle.
module hrlt_handle_scan #(
  parameter int unsigned Handles = hrlt_pkg::HandlesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hrlt_pkg::scan_req_t       req_i,
  input  logic [Handles-1:0]        busy_i,
  output hrlt_pkg::scan_rsp_t       rsp_o,
  output logic [$clog2(Handles)-1:0] handle_o
);
  import hrlt_pkg::*;

  localparam int unsigned HIdxW = $clog2(Handles);
  localparam int unsigned HCntW = $clog2(Handles + 1);

  logic [HCntW-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic             found_q, found_d;

  always_comb begin
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    found_d = found_q;
    if (req_i.start) begin
      cnt_d   = '0;
      run_d   = 1'b1;
      found_d = 1'b0;
    end else if (run_q) begin
      if (cnt_q == HCntW'(Handles)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (!busy_i[cnt_q[HIdxW-1:0]]) begin
        run_d   = 1'b0;
        done_d  = 1'b1;
        found_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.found = found_q;
  assign handle_o    = cnt_q[HIdxW-1:0];

  a_found_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && found_q) |-> !busy_i[cnt_q[HIdxW-1:0]])
    else $error("scanner reported a busy handle as free");

  a_one_shot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("scanner done held longer than one cycle");

  a_no_run_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("scanner still running while done");

endmodule

/* hw/rtl/hashed_record_lock_table.sv */
// Top level of the hashed record lock table.
// Exclusive record lock manager. Each request is handled alone; in_stall_o stays high until
// its results are taken. After the request is taken, an acquire reads its bucket head, walks
// the chain one entry at a time, runs the free-handle scan and updates the record before its
// result is offered; a full table or pool goes straight to the result. A release reads the
// handle, checks it and then reads its record entry; a handle that is out of range or not
// busy goes straight to the result. Each result is held until out_stall_i is low, and the
// block returns to idle before it takes the next request. The chain walk goes through the
// entry memory's single read port, and the scan checks one handle per cycle. No clearing
// pass is needed after reset: bucket and busy bits reset at once, and entries are only read
// once written.
module hashed_record_lock_table #(
  parameter int unsigned Buckets = hrlt_pkg::BucketsDefault,
  parameter int unsigned Entries = hrlt_pkg::EntriesDefault,
  parameter int unsigned Handles = hrlt_pkg::HandlesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [hrlt_pkg::TableW-1:0]  table_id_i,
  input  logic signed [hrlt_pkg::KeyW-1:0] record_key_i,
  input  logic [hrlt_pkg::HandleW-1:0] lock_handle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hrlt_pkg::StatusW-1:0] status_o,
  output logic [hrlt_pkg::HandleW-1:0] handle_out_o,
  output logic                         last_o
);
  import hrlt_pkg::*;

  localparam int unsigned BIdxW = $clog2(Buckets);
  localparam int unsigned EIdxW = $clog2(Entries);
  localparam int unsigned ECntW = $clog2(Entries + 1);
  localparam int unsigned HIdxW = $clog2(Handles);

  // Bucket heads with valid bits.
  logic [Buckets-1:0] bkt_vld_q;
  logic [EIdxW-1:0]   bkt_head_mem [Buckets];
  logic [EIdxW-1:0]   bkt_head_rd_q;

  // Entry store.
  logic [TableW-1:0]  ent_tab_mem  [Entries];
  logic [KeyW-1:0]    ent_key_mem  [Entries];
  logic               ent_cv_mem   [Entries];
  logic [EIdxW-1:0]   ent_cn_mem   [Entries];
  logic               ent_qv_mem   [Entries];
  logic [HIdxW-1:0]   ent_qh_mem   [Entries];
  logic [HIdxW-1:0]   ent_qt_mem   [Entries];

  // Handle store.
  logic [Handles-1:0] busy_q;
  logic               hnv_mem [Handles];
  logic [HIdxW-1:0]   hn_mem  [Handles];
  logic [EIdxW-1:0]   hrec_mem [Handles];

  state_e state_q, state_d;

  logic [TableW-1:0]  tab_q;
  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] rh_q;
  logic [BIdxW-1:0]   bkt_q;
  logic [EIdxW-1:0]   cur_q, cur_d;
  logic               found_q, found_d;
  logic [ECntW-1:0]   used_q, used_d;
  logic [ECntW-1:0]   steps_q, steps_d;

  // Entry read port results.
  logic [TableW-1:0]  rd_tab_q;
  logic [KeyW-1:0]    rd_key_q;
  logic               rd_cv_q, rd_qv_q;
  logic [EIdxW-1:0]   rd_cn_q;
  logic [HIdxW-1:0]   rd_qh_q, rd_qt_q;
  logic [EIdxW-1:0]   rd_addr;
  logic               rd_hnv_q;
  logic [HIdxW-1:0]   rd_hn_q;
  logic [EIdxW-1:0]   rd_hrec_q;
  logic [HIdxW-1:0]   hrd_addr;

  logic [StatusW-1:0] st1_q, st1_d, st2_q, st2_d;
  logic [HandleW-1:0] h1_q, h1_d, h2_q, h2_d;
  logic               two_q, two_d;

  scan_req_t        scan_req;
  scan_rsp_t        scan_rsp;
  logic [HIdxW-1:0] scan_h;

  // Write controls.
  logic             ent_new_we;
  logic             ent_q_we;
  logic [EIdxW-1:0] ent_q_addr;
  logic             ent_q_v;
  logic [HIdxW-1:0] ent_q_h, ent_q_t;
  logic             ent_qt_only_we;
  logic             h_alloc_we;
  logic             hn_link_we;
  logic             hn_clr_we;
  logic             busy_clr;
  logic             in_take;
  logic             rel_ok;

  hrlt_handle_scan #(.Handles(Handles)) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (scan_req),
    .busy_i   (busy_q),
    .rsp_o    (scan_rsp),
    .handle_o (scan_h)
  );

  assign in_stall_o = (state_q != SIdle);
  assign in_take    = in_valid_i && !in_stall_o;
  assign rd_addr    = cur_q;
  assign hrd_addr   = rh_q[HIdxW-1:0];

  // Register reads of the memories.
  always_ff @(posedge clk_i) begin
    bkt_head_rd_q <= bkt_head_mem[bkt_q];
    rd_tab_q  <= ent_tab_mem[rd_addr];
    rd_key_q  <= ent_key_mem[rd_addr];
    rd_cv_q   <= ent_cv_mem[rd_addr];
    rd_cn_q   <= ent_cn_mem[rd_addr];
    rd_qv_q   <= ent_qv_mem[rd_addr];
    rd_qh_q   <= ent_qh_mem[rd_addr];
    rd_qt_q   <= ent_qt_mem[rd_addr];
    rd_hnv_q  <= hnv_mem[hrd_addr];
    rd_hn_q   <= hn_mem[hrd_addr];
    rd_hrec_q <= hrec_mem[hrd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ent_new_we) begin
      ent_tab_mem[used_q[EIdxW-1:0]] <= tab_q;
      ent_key_mem[used_q[EIdxW-1:0]] <= key_q;
      ent_cv_mem[used_q[EIdxW-1:0]]  <= bkt_vld_q[bkt_q];
      ent_cn_mem[used_q[EIdxW-1:0]]  <= bkt_head_rd_q;
      bkt_head_mem[bkt_q]            <= used_q[EIdxW-1:0];
    end
    if (ent_q_we) begin
      ent_qv_mem[ent_q_addr] <= ent_q_v;
      ent_qh_mem[ent_q_addr] <= ent_q_h;
      ent_qt_mem[ent_q_addr] <= ent_q_t;
    end
    if (ent_qt_only_we) begin
      ent_qt_mem[ent_q_addr] <= ent_q_t;
    end
    if (h_alloc_we) begin
      hrec_mem[scan_h] <= cur_q;
    end
    if (hn_link_we) begin
      hnv_mem[rd_qt_q] <= 1'b1;
      hn_mem[rd_qt_q]  <= scan_h;
    end
    if (h_alloc_we) begin
      hnv_mem[scan_h] <= 1'b0;
    end else if (hn_clr_we) begin
      hnv_mem[hrd_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tab_q <= table_id_i;
      key_q <= record_key_i;
      rh_q  <= lock_handle_i;
      bkt_q <= BIdxW'(record_key_i + {{(KeyW-TableW){1'b0}}, table_id_i});
    end
  end

  assign rel_ok = (rh_q < Handles) && busy_q[hrd_addr];

  always_comb begin
    state_d        = state_q;
    cur_d          = cur_q;
    found_d        = found_q;
    used_d         = used_q;
    steps_d        = steps_q;
    st1_d          = st1_q;
    st2_d          = st2_q;
    h1_d           = h1_q;
    h2_d           = h2_q;
    two_d          = two_q;
    scan_req.start = 1'b0;
    ent_new_we     = 1'b0;
    ent_q_we       = 1'b0;
    ent_qt_only_we = 1'b0;
    ent_q_addr     = cur_q;
    ent_q_v        = 1'b0;
    ent_q_h        = scan_h;
    ent_q_t        = scan_h;
    h_alloc_we     = 1'b0;
    hn_link_we     = 1'b0;
    hn_clr_we      = 1'b0;
    busy_clr       = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_take) begin
          two_d   = 1'b0;
          found_d = 1'b0;
          steps_d = '0;
          state_d = (op_i == OpRelease) ? SRelRd : SBktRd;
        end
      end
      SBktRd: state_d = SHash;
      SHash: begin
        if (bkt_vld_q[bkt_q]) begin
          cur_d   = bkt_head_rd_q;
          state_d = SWalkRd;
        end else begin
          scan_req.start = 1'b1;
          state_d = SHandleScan;
        end
      end
      SWalkRd: state_d = SWalkCmp;
      SWalkCmp: begin
        if (rd_tab_q == tab_q && rd_key_q == key_q) begin
          found_d = 1'b1;
          scan_req.start = 1'b1;
          state_d = SHandleScan;
        end else if (rd_cv_q && (steps_q + 1'b1) < ECntW'(Entries)) begin
          cur_d   = rd_cn_q;
          steps_d = steps_q + 1'b1;
          state_d = SWalkRd;
        end else begin
          scan_req.start = 1'b1;
          state_d = SHandleScan;
        end
      end
      SHandleScan: begin
        if (scan_rsp.done) begin
          if (!found_q && used_q >= ECntW'(Entries)) begin
            st1_d = StRecFull; h1_d = '0; state_d = SOut1;
          end else if (!scan_rsp.found) begin
            st1_d = StPoolFull; h1_d = '0; state_d = SOut1;
          end else if (!found_q) begin
            ent_new_we = 1'b1;
            cur_d      = used_q[EIdxW-1:0];
            used_d     = used_q + 1'b1;
            state_d    = SDecide;
          end else begin
            state_d = SQueueRd;
          end
        end
      end
      SQueueRd: state_d = SDecide;
      SDecide: begin
        h_alloc_we = 1'b1;
        h1_d = HandleW'(scan_h);
        if (found_q && rd_qv_q) begin
          hn_link_we     = 1'b1;
          ent_qt_only_we = 1'b1;
          st1_d = StQueued;
        end else begin
          ent_q_we = 1'b1;
          ent_q_v  = 1'b1;
          st1_d = StGranted;
        end
        state_d = SOut1;
      end
      SRelRd: state_d = SRelChk;
      SRelChk: begin
        // The handle's record index is valid now; its entry is read via cur_q in SRelWait.
        cur_d   = rd_hrec_q;
        state_d = SRelWait;
        if (!rel_ok) begin
          st1_d = StBadHandle; h1_d = rh_q; state_d = SOut1;
        end
      end
      SRelWait: state_d = SRelNext;
      SRelNext: begin
        if (!rd_qv_q || rd_qh_q != hrd_addr) begin
          st1_d = StBadHandle; h1_d = rh_q;
        end else begin
          busy_clr = 1'b1;
          st1_d = StReleased; h1_d = rh_q;
          if (rd_hnv_q) begin
            hn_clr_we = 1'b1;
            ent_qt_only_we = 1'b0;
            ent_q_we = 1'b1;
            ent_q_v  = 1'b1;
            ent_q_h  = rd_hn_q;
            ent_q_t  = rd_qt_q;
            two_d = 1'b1;
            st2_d = StWaiter; h2_d = HandleW'(rd_hn_q);
          end else begin
            ent_q_we = 1'b1;
            ent_q_v  = 1'b0;
            ent_q_h  = rd_qh_q;
            ent_q_t  = rd_qt_q;
          end
        end
        state_d = SOut1;
      end
      SOut1: begin
        if (!out_stall_i) state_d = two_q ? SOut2 : SIdle;
      end
      SOut2: begin
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      bkt_vld_q <= '0;
      busy_q    <= '0;
      used_q    <= '0;
      found_q   <= 1'b0;
      two_q     <= 1'b0;
      steps_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      found_q <= found_d;
      two_q   <= two_d;
      steps_q <= steps_d;
      if (ent_new_we) bkt_vld_q[bkt_q] <= 1'b1;
      if (h_alloc_we) busy_q[scan_h] <= 1'b1;
      if (busy_clr) busy_q[hrd_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    st1_q <= st1_d;
    st2_q <= st2_d;
    h1_q  <= h1_d;
    h2_q  <= h2_d;
  end

  assign out_valid_o  = (state_q == SOut1) || (state_q == SOut2);
  assign status_o     = (state_q == SOut2) ? st2_q : st1_q;
  assign handle_out_o = (state_q == SOut2) ? h2_q : h1_q;
  assign last_o       = (state_q == SOut2) || !two_q;

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ECntW'(Entries))
    else $error("entry count beyond table size");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall_o)
    else $error("request accepted while busy");

  a_second_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut2) |-> two_q)
    else $error("second result without a waiter");

endmodule
